>>> rtl/core/lfa_pkg.sv
// Shared types, codes and constants of the lowest-free id allocator.
package lfa_pkg;

  // Default highest id that the store holds
  localparam int unsigned MAX_ID_DEF = 255;

  // Bitmap word width and id widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFS_W  = $clog2(WORD_W);
  localparam int unsigned ID_W   = 9;
  localparam int unsigned CFG_W  = 8;

  // APB data and address widths
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Register indexes
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] RANGE_LOW_RST  = 8'd1;
  localparam logic [CFG_W-1:0] RANGE_HIGH_RST = 8'd255;

  // Action codes
  typedef enum logic [1:0] {
    ACT_TAKE    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2
  } action_e;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]       action;
    logic [CFG_W-1:0] id_in;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            ok;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_take;
    logic hit;
    logic last;
  } dp_status_t;

endpackage

>>> rtl/core/lfa_ctrl.sv
// Controller: sequences one transaction at a time and owns the result valid.
module lfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lfa_pkg::dp_status_t status_i,
  output lfa_pkg::dp_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_OP   = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;
  logic done;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Result slot can take a new value if empty or draining this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // Release, query and unused codes finish at once; a take finishes on a hit or the last word
  assign done = !status_i.is_take || status_i.hit || status_i.last;

  always_comb begin
    cmd_o.load    = in_valid_i && in_ready_o;
    cmd_o.commit  = (state_q == ST_OP) && done && slot_free;
    cmd_o.advance = (state_q == ST_OP) && status_i.is_take && !status_i.hit &&
                    !status_i.last;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_OP;
      end
      ST_OP: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/lfa_dpath.sv
// Datapath: used-id bitmap, word scan with priority encoder, result register.
module lfa_dpath #(
  parameter int unsigned MAX_ID = lfa_pkg::MAX_ID_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lfa_pkg::dp_cmd_t                 cmd_i,
  output lfa_pkg::dp_status_t              status_o,
  input  lfa_pkg::in_t                     in_data_i,
  input  logic [lfa_pkg::CFG_W-1:0]        range_low_i,
  input  logic [lfa_pkg::CFG_W-1:0]        range_high_i,
  output lfa_pkg::out_t                    out_data_o
);

  localparam int unsigned WORD_W = lfa_pkg::WORD_W;
  localparam int unsigned OFS_W  = lfa_pkg::OFS_W;
  localparam int unsigned ID_W   = lfa_pkg::ID_W;
  // Ids above 256 can never be granted, released or queried
  localparam int unsigned CAP       = (MAX_ID > 256) ? 256 : MAX_ID;
  localparam int unsigned NUM_WORDS = (CAP + WORD_W) / WORD_W;
  localparam int unsigned PTR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [ID_W-1:0] CAP_ID    = ID_W'(CAP);
  localparam logic [ID_W-1:0] LO_MAX    = ID_W'(CAP - 1);
  localparam logic [ID_W-1:0] WORDS_ID  = ID_W'(NUM_WORDS);
  localparam logic [ID_W-1:0] ID_ONE    = ID_W'(1);
  localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(WORD_W - 1);

  logic [NUM_WORDS-1:0][WORD_W-1:0] map_q;
  logic [1:0]                       act_q;
  logic [lfa_pkg::CFG_W-1:0]        id_q;
  logic [PTR_W-1:0]                 ptr_q, ptr_d;
  lfa_pkg::out_t                    out_q, res;

  logic [ID_W-1:0]   lo_raw, lo, hi_raw, hi, lo_wd, hi_wd, ptr_ext, id_ext;
  logic              ptr_ok;
  logic [WORD_W-1:0] cur_word, lo_mask, hi_mask, free, new_word;
  logic [OFS_W-1:0]  pos;
  logic              hit, id_ok, taken, is_take, is_rel, wr_en;

  // Effective range
  always_comb begin
    lo_raw = (range_low_i == '0) ? ID_ONE : ID_W'(range_low_i);
    lo     = (lo_raw > LO_MAX) ? LO_MAX : lo_raw;
    hi_raw = (ID_W'(range_high_i) <= lo) ? lo + ID_ONE : ID_W'(range_high_i);
    hi     = (hi_raw > CAP_ID) ? CAP_ID : hi_raw;
    lo_wd  = lo >> OFS_W;
    hi_wd  = hi >> OFS_W;
  end

  // Current bitmap word
  assign ptr_ext  = ID_W'(ptr_q);
  assign ptr_ok   = ptr_ext < WORDS_ID;
  assign cur_word = ptr_ok ? map_q[ptr_q] : '0;

  // Free bits of the current word inside the range
  always_comb begin
    lo_mask = (ptr_ext == lo_wd) ? ({WORD_W{1'b1}} << lo[OFS_W-1:0]) : {WORD_W{1'b1}};
    hi_mask = (ptr_ext == hi_wd) ? ({WORD_W{1'b1}} >> (OFS_LAST - hi[OFS_W-1:0]))
                                 : {WORD_W{1'b1}};
    free    = ~cur_word & lo_mask & hi_mask;
    hit     = |free;
  end

  // Lowest free bit
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free[i]) pos = OFS_W'(i);
    end
  end

  // Release and query lookup
  assign id_ext = ID_W'(id_q);
  assign id_ok  = id_ext <= CAP_ID;
  assign taken  = id_ok && cur_word[id_q[OFS_W-1:0]];

  assign is_take = (act_q == lfa_pkg::ACT_TAKE);
  assign is_rel  = (act_q == lfa_pkg::ACT_RELEASE);

  always_comb begin
    status_o.is_take = is_take;
    status_o.hit     = hit;
    status_o.last    = ptr_ext >= hi_wd;
  end

  // Result of the transaction
  always_comb begin
    res = '0;
    case (act_q)
      lfa_pkg::ACT_TAKE: begin
        res.granted_id = hit ? ((ptr_ext << OFS_W) | ID_W'(pos)) : hi + ID_ONE;
        res.ok         = hit;
      end
      lfa_pkg::ACT_RELEASE: res.ok = taken;
      lfa_pkg::ACT_QUERY:   res.ok = taken;
      default:              res = '0;
    endcase
  end

  // Bitmap update: set the granted bit or clear the released one
  always_comb begin
    new_word = cur_word;
    wr_en    = 1'b0;
    if (is_take && hit) begin
      new_word = cur_word | (WORD_W'(1) << pos);
      wr_en    = 1'b1;
    end else if (is_rel && taken) begin
      new_word = cur_word & ~(WORD_W'(1) << id_q[OFS_W-1:0]);
      wr_en    = 1'b1;
    end
  end

  // Word pointer
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      if (in_data_i.action == lfa_pkg::ACT_TAKE) begin
        ptr_d = PTR_W'(lo_wd);
      end else begin
        ptr_d = PTR_W'(in_data_i.id_in >> OFS_W);
      end
    end else if (cmd_i.advance) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (cmd_i.commit && wr_en && ptr_ok) begin
      map_q[ptr_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      act_q <= in_data_i.action;
      id_q  <= in_data_i.id_in;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/lowest_free_id_allocator.sv
// Top level: APB range registers, controller and bitmap datapath.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    in_data_i  (action, id_in)
//   out       output     out_valid_o / out_ready_i  out_data_o (granted_id, ok)
//   apb       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Release and query are accepted and then do one bitmap word lookup.
// A take is accepted and then scans the 32-bit bitmap words from the effective
// low's word up to the first with a free id or the high's word (at most 9 words).
// A finished result waits in the output register; the next transaction is
// accepted meanwhile and holds its commit until that register drains.
// Reset clears the bitmap at once, so no id is taken; no clearing pass follows.
module lowest_free_id_allocator #(
  parameter int unsigned MAX_ID = lfa_pkg::MAX_ID_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lfa_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfa_pkg::out_t                 out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfa_pkg::APB_AW-1:0]    paddr,
  input  logic [lfa_pkg::APB_DW-1:0]    pwdata,
  output logic [lfa_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [lfa_pkg::CFG_W-1:0] range_low_q, range_high_q;
  logic                      wr_en;
  logic                      reg_sel;
  lfa_pkg::dp_cmd_t          cmd;
  lfa_pkg::dp_status_t       status;

  // APB register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= lfa_pkg::RANGE_LOW_RST;
      range_high_q <= lfa_pkg::RANGE_HIGH_RST;
    end else if (wr_en) begin
      if (reg_sel == lfa_pkg::REG_RANGE_LOW) begin
        range_low_q <= pwdata[lfa_pkg::CFG_W-1:0];
      end else begin
        range_high_q <= pwdata[lfa_pkg::CFG_W-1:0];
      end
    end
  end

  // Read data
  always_comb begin
    case (reg_sel)
      lfa_pkg::REG_RANGE_LOW:  prdata = lfa_pkg::APB_DW'(range_low_q);
      lfa_pkg::REG_RANGE_HIGH: prdata = lfa_pkg::APB_DW'(range_high_q);
      default:                 prdata = '0;
    endcase
  end

  lfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfa_dpath #(
    .MAX_ID (MAX_ID)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (in_data_i),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .out_data_o   (out_data_o)
  );

endmodule

>>> bench/lowest_free_id_allocator_tb.sv
// Self-checking testbench for the lowest-free id allocator: directed table, then random phases.
module lowest_free_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ID      = lfa_pkg::MAX_ID_DEF;
  localparam logic [1:0]  ACT_SPARE   = 2'd3;     // unused action code
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASES      = 24;
  localparam int unsigned PHASE_TXNS  = 77;
  localparam int unsigned DIR_ROWS    = 31;

  // Directed table row: a transaction or a register write
  typedef enum logic [1:0] {
    ROW_TXN,
    ROW_SET_LOW,
    ROW_SET_HIGH
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [1:0]                action;
    logic [lfa_pkg::CFG_W-1:0] arg;
    logic                      pinned;
    logic [lfa_pkg::ID_W-1:0]  gid;
    logic                      ok;
  } dir_row_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  lfa_pkg::in_t                 in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  lfa_pkg::out_t                out_data;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [lfa_pkg::APB_AW-1:0]   paddr     = '0;
  logic [lfa_pkg::APB_DW-1:0]   pwdata    = '0;
  logic [lfa_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  // Predictor state: range registers and taken-id bitmap
  logic [lfa_pkg::CFG_W-1:0]    cfg_low   = lfa_pkg::RANGE_LOW_RST;
  logic [lfa_pkg::CFG_W-1:0]    cfg_high  = lfa_pkg::RANGE_HIGH_RST;
  logic                         used_map [0:MAX_ID];

  lfa_pkg::out_t                grant_q [$];
  int unsigned                  err_cnt   = 0;
  int unsigned                  cycles    = 0;
  bit                           idle_en   = 1'b1;
  int unsigned                  hold_reqs = 0;
  int unsigned                  hold_seen = 0;
  int unsigned                  hold_left = 0;

  // Directed stimulus; pinned rows carry their expected result
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TXN,      lfa_pkg::ACT_QUERY,   8'd0,   1'b1, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b1, 9'd1,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'hFF,  1'b1, 9'd2,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_QUERY,   8'd1,   1'b1, 9'd0,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_QUERY,   8'd255, 1'b1, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_RELEASE, 8'd1,   1'b1, 9'd0,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_RELEASE, 8'd1,   1'b1, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b1, 9'd1,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_RELEASE, 8'd0,   1'b1, 9'd0,   1'b0},
    '{ROW_TXN,      ACT_SPARE,            8'hAA,  1'b1, 9'd0,   1'b0},
    '{ROW_TXN,      ACT_SPARE,            8'h55,  1'b1, 9'd0,   1'b0},
    // high not above low: range becomes 250..251
    '{ROW_SET_LOW,  lfa_pkg::ACT_TAKE,    8'd250, 1'b0, 9'd0,   1'b0},
    '{ROW_SET_HIGH, lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b1, 9'd252, 1'b0},
    // ids outside the range still live in the bitmap
    '{ROW_TXN,      lfa_pkg::ACT_QUERY,   8'd2,   1'b1, 9'd0,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_RELEASE, 8'd2,   1'b1, 9'd0,   1'b1},
    // low at the top clamps to 254..255
    '{ROW_SET_LOW,  lfa_pkg::ACT_TAKE,    8'd255, 1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b1, 9'd256, 1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_QUERY,   8'd255, 1'b1, 9'd0,   1'b1},
    '{ROW_TXN,      lfa_pkg::ACT_RELEASE, 8'd255, 1'b1, 9'd0,   1'b1},
    // low of zero acts as one: range 1..3
    '{ROW_SET_LOW,  lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_SET_HIGH, lfa_pkg::ACT_TAKE,    8'd3,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_TAKE,    8'd0,   1'b1, 9'd4,   1'b0},
    '{ROW_SET_HIGH, lfa_pkg::ACT_TAKE,    8'd255, 1'b0, 9'd0,   1'b0},
    '{ROW_TXN,      lfa_pkg::ACT_RELEASE, 8'd1,   1'b0, 9'd0,   1'b0}
  };

  lowest_free_id_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (used_map[i]) used_map[i] = 1'b0;
  end

  task automatic report_err(string what);
    err_cnt++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Lowest free id of the effective range, bitmap update on take and release
  function automatic lfa_pkg::out_t predict_alloc(lfa_pkg::in_t t);
    lfa_pkg::out_t r;
    int   lo;
    int   hi;
    bit   found;
    r     = '0;
    found = 1'b0;
    case (t.action)
      lfa_pkg::ACT_TAKE: begin
        lo = (cfg_low == 0) ? 1 : int'(cfg_low);
        if (lo > int'(MAX_ID) - 1) lo = int'(MAX_ID) - 1;
        hi = (int'(cfg_high) <= lo) ? lo + 1 : int'(cfg_high);
        if (hi > int'(MAX_ID)) hi = int'(MAX_ID);
        r.granted_id = lfa_pkg::ID_W'(hi + 1);
        for (int k = lo; k <= hi; k++) begin
          if (!found && !used_map[k]) begin
            found        = 1'b1;
            used_map[k]  = 1'b1;
            r.granted_id = lfa_pkg::ID_W'(k);
            r.ok         = 1'b1;
          end
        end
      end
      lfa_pkg::ACT_RELEASE: begin
        if (int'(t.id_in) <= int'(MAX_ID) && used_map[t.id_in]) begin
          used_map[t.id_in] = 1'b0;
          r.ok              = 1'b1;
        end
      end
      lfa_pkg::ACT_QUERY: begin
        if (int'(t.id_in) <= int'(MAX_ID) && used_map[t.id_in]) r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one transaction; queue its expected result once accepted
  task automatic send_txn(lfa_pkg::in_t t, bit pinned, lfa_pkg::out_t pinned_res);
    lfa_pkg::out_t res;
    if (idle_en && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_alloc(t);
    grant_q.insert(grant_q.size(), pinned ? pinned_res : res);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  // APB write with read-back, only while the block is idle
  task automatic write_reg(logic idx, logic [lfa_pkg::CFG_W-1:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(lfa_pkg::APB_DW-lfa_pkg::CFG_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == lfa_pkg::REG_RANGE_LOW) cfg_low = val;
    else cfg_high = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(lfa_pkg::APB_DW-lfa_pkg::CFG_W){1'b0}}, val})
      report_err($sformatf("reg %0d reads %0h, expected %0h", idx, prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Some id that the bitmap holds as taken, or a random one if none is
  function automatic logic [lfa_pkg::CFG_W-1:0] taken_id();
    int start;
    int pick;
    start = $urandom_range(0, MAX_ID);
    pick  = start;
    for (int k = int'(MAX_ID); k >= 0; k--) begin
      if (used_map[(start + k) % (MAX_ID + 1)]) pick = (start + k) % (MAX_ID + 1);
    end
    return lfa_pkg::CFG_W'(pick);
  endfunction

  // Random transaction, biased toward releases and queries of taken ids
  function automatic lfa_pkg::in_t next_item();
    lfa_pkg::in_t t;
    int  roll;
    roll     = $urandom_range(0, 99);
    t.id_in  = lfa_pkg::CFG_W'($urandom_range(0, 255));
    if (roll < 45) begin
      t.action = lfa_pkg::ACT_TAKE;
    end else if (roll < 75) begin
      t.action = lfa_pkg::ACT_RELEASE;
      if ($urandom_range(0, 9) < 7) t.id_in = taken_id();
    end else if (roll < 95) begin
      t.action = lfa_pkg::ACT_QUERY;
      if ($urandom_range(0, 1) == 1) t.id_in = taken_id();
    end else begin
      t.action = ACT_SPARE;
    end
    return t;
  endfunction

  // New range for a random phase, extremes included
  task automatic set_random_range();
    int lo;
    int hi;
    case ($urandom_range(0, 5))
      0: begin lo = $urandom_range(0, 3);   hi = 255; end
      1: begin lo = $urandom_range(0, 250); hi = lo + $urandom_range(0, 5); end
      2: begin lo = $urandom_range(1, 255); hi = $urandom_range(0, lo); end
      3: begin lo = $urandom_range(254, 255); hi = 255; end
      4: begin lo = 0; hi = 0; end
      default: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 255); end
    endcase
    write_reg(lfa_pkg::REG_RANGE_LOW, lfa_pkg::CFG_W'(lo));
    write_reg(lfa_pkg::REG_RANGE_HIGH, lfa_pkg::CFG_W'(hi));
  endtask

  // Stimulus
  initial begin : stim
    lfa_pkg::in_t  t;
    lfa_pkg::out_t res;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      case (dir_tab[r].kind)
        ROW_SET_LOW:  write_reg(lfa_pkg::REG_RANGE_LOW, dir_tab[r].arg);
        ROW_SET_HIGH: write_reg(lfa_pkg::REG_RANGE_HIGH, dir_tab[r].arg);
        default: begin
          t.action     = dir_tab[r].action;
          t.id_in      = dir_tab[r].arg;
          res.granted_id = dir_tab[r].gid;
          res.ok         = dir_tab[r].ok;
          send_txn(t, dir_tab[r].pinned, res);
        end
      endcase
    end

    for (int ph = 0; ph < int'(PHASES); ph++) begin
      set_random_range();
      idle_en = (ph < 8 || ph > 10);
      // receiver stalls long enough for the input to back up
      if (ph == 2 || ph == 15) hold_reqs++;
      for (int n = 0; n < int'(PHASE_TXNS); n++) begin
        if (ph == 5 && n == int'(PHASE_TXNS) / 2) drain();
        send_txn(next_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stalls plus requested long holds
  always @(posedge clk) begin : rx
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_en && $urandom_range(0, 99) < 20);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : mon
    lfa_pkg::out_t got;
    lfa_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (grant_q.size() == 0) begin
        report_err($sformatf("unexpected result id %0d ok %0b", got.granted_id, got.ok));
      end else begin
        want = grant_q.pop_front();
        if (got.granted_id !== want.granted_id)
          report_err($sformatf("granted_id %0d, expected %0d",
                               got.granted_id, want.granted_id));
        if (got.ok !== want.ok)
          report_err($sformatf("ok %0b, expected %0b", got.ok, want.ok));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/core/lfa_pkg.sv
rtl/core/lfa_ctrl.sv
rtl/core/lfa_dpath.sv
rtl/core/lowest_free_id_allocator.sv
bench/lowest_free_id_allocator_tb.sv
